>>> src/mslte_pkg.sv
// Package for the multi-slot linear tween engine: payload structs, action codes,
// sequencer states. Used by every module in src.
`timescale 1ns / 1ps
package mslte_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_TICK   = 2'd1,
        ACT_CANCEL = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         slot;
        logic signed [15:0] start_value;
        logic signed [15:0] stop_value;
        logic [15:0]        duration;
        logic [15:0]        return_duration;
        logic               loop_forever;
        logic [15:0]        elapsed;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         out_slot;
        logic signed [15:0] value;
        logic               finished;
        logic               last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV,
        ST_EMIT,
        ST_NEXT
    } t_state;

    // Divider handshake between sequencer and divider unit.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

endpackage

>>> src/multi_slot_linear_tween_engine.sv
// Multi-slot linear tween engine: top level, slot memory and tick sequencer.
// Depends on mslte_pkg and mslte_div.
//
// Usage: one input channel (i_in_valid / o_in_stall, i_in_data) carries load,
// tick and cancel transfers; one output channel (o_out_valid / i_out_stall,
// o_out_data) carries one result per reporting slot of a tick, the last one
// flagged with last. Load and cancel complete in the accepting cycle, produce
// nothing and leave the input free on the next cycle. A tick walks every slot
// in index order. An idle slot passes through the read and advance states. An
// active slot passes through read, evaluate, emit and advance; in mid-phase it
// also holds the walk for a serial division by the single serial divider. One
// item is worked on at a time; o_in_stall is high while a tick is in progress.
// When the receiver stalls, the result register holds and the walk waits.
// Reset clears the active bits and the sequencer; the slot memory contents are
// left undefined until loaded.
`timescale 1ns / 1ps
module multi_slot_linear_tween_engine import mslte_pkg::*; #(
    parameter int SLOTS      = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CWD = $clog2(SLOTS + 1);
    localparam int VB  = VALUE_BITS;
    localparam int NB  = VB + 1 + 16 + 1;
    localparam int EW  = 2 * VB + 2 * 16 + 3;

    // memory entry: start, stop, fwd, back, repeat, reversed, clock
    typedef struct packed {
        logic [VB-1:0] st;
        logic [VB-1:0] sp;
        logic [15:0]   fwd;
        logic [15:0]   bck;
        logic          rep;
        logic          rev;
        logic [15:0]   clk;
    } t_entry;

    t_entry        r_mem [SLOTS];
    t_entry        r_rd;
    logic [SLOTS-1:0] r_active;

    t_state        r_state, n_state;
    t_in_item      r_item;
    logic [CWD-1:0] r_idx;
    logic [SW-1:0]  w_idx;

    logic          w_accept, w_out_free;
    logic          w_we;
    t_entry        w_wdata;
    logic [SW-1:0] w_waddr;

    // evaluate registers
    logic signed [VB-1:0] r_a, r_val;
    logic                 r_fin, r_emit;
    logic [15:0]          r_dur;
    logic [16:0]          w_sum;
    logic [15:0]          w_clk;
    logic [15:0]          w_dur;
    logic                 w_wrap;
    logic signed [VB:0]   w_dist;

    // divider
    logic                 w_div_start;
    logic signed [NB-1:0] r_num;
    t_div_ctl             w_div;
    logic signed [NB-1:0] w_quot;
    logic                 r_started;

    logic       r_ovalid;
    t_out_item  r_odata;

    // result held one back for the last flag
    logic      r_hold_v;
    t_out_item r_hold;
    logic      w_push, w_flush;

    assign w_idx      = r_idx[SW-1:0];
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept && (i_in_data.action == ACT_TICK)) n_state = ST_READ;
            ST_READ: n_state = r_active[w_idx] ? ST_EVAL : ST_NEXT;
            ST_EVAL: n_state = w_wrap ? ST_EMIT : ST_DIV;
            ST_DIV:  if (w_div.done) n_state = ST_EMIT;
            ST_EMIT: if (!r_emit || w_out_free) n_state = ST_NEXT;
            ST_NEXT: begin
                if (r_idx != CWD'(SLOTS - 1)) n_state = ST_READ;
                else if (!r_hold_v || w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        w_sum  = {1'b0, r_rd.clk} + {1'b0, r_item.elapsed};
        w_clk  = w_sum[16] ? 16'hFFFF : w_sum[15:0];
        w_dur  = r_rd.rev ? r_rd.bck : r_rd.fwd;
        w_wrap = (w_clk > w_dur) || (w_dur == 16'd0);
        w_dist = $signed({r_rd.sp[VB-1], r_rd.sp}) - $signed({r_rd.st[VB-1], r_rd.st});
        w_we    = 1'b0;
        w_waddr = w_idx;
        w_wdata = r_rd;
        if (r_state == ST_EVAL) begin
            w_we = 1'b1;
            w_wdata.clk = w_clk;
            if (w_wrap && r_rd.rep) begin
                w_wdata.clk = '0;
                if (r_rd.bck != 16'd0) begin
                    w_wdata.rev = !r_rd.rev;
                    w_wdata.st  = r_rd.sp;
                    w_wdata.sp  = r_rd.st;
                end
            end
        end else if (w_accept && (i_in_data.action == ACT_LOAD)) begin
            w_we    = (32'(i_in_data.slot) < SLOTS) && (i_in_data.duration != 16'd0);
            w_waddr = SW'(i_in_data.slot);
            w_wdata.st  = VB'($signed(i_in_data.start_value));
            w_wdata.sp  = VB'($signed(i_in_data.stop_value));
            w_wdata.fwd = i_in_data.duration;
            w_wdata.bck = i_in_data.return_duration;
            w_wdata.rep = i_in_data.loop_forever;
            w_wdata.rev = 1'b0;
            w_wdata.clk = '0;
        end
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[w_idx];
    end

    // active bits, sequencer and walk index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_state  <= ST_IDLE;
            r_idx    <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept && (32'(i_in_data.slot) < SLOTS)) begin
                if (i_in_data.action == ACT_LOAD && i_in_data.duration != 16'd0)
                    r_active[SW'(i_in_data.slot)] <= 1'b1;
                else if (i_in_data.action == ACT_CANCEL)
                    r_active[SW'(i_in_data.slot)] <= 1'b0;
            end
            if (r_state == ST_EVAL && w_wrap && !r_rd.rep) r_active[w_idx] <= 1'b0;
            if (r_state == ST_IDLE) begin
                r_idx <= '0;
            end else if (r_state == ST_NEXT && n_state != ST_NEXT) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // hold the item and the evaluate results
    always_ff @(posedge i_clk) begin
        if (w_accept) r_item <= i_in_data;
        if (r_state == ST_EVAL) begin
            r_a    <= r_rd.st;
            r_dur  <= w_dur;
            r_val  <= r_rd.sp;
            r_fin  <= w_wrap && !r_rd.rep;
            r_emit <= (w_dist != '0) || (w_wrap && !r_rd.rep);
            r_num  <= NB'(w_dist) * $signed({1'b0, w_clk});
        end
        if (r_state == ST_DIV && w_div.done) r_val <= VB'(r_a + VB'(w_quot));
    end

    // start the divider on the first cycle of a division phase
    assign w_div_start = (r_state == ST_DIV) && !w_div.busy && !w_div.done
                         && (r_dur != 16'd0) && !r_started;

    mslte_div #(.NUM_BITS(NB), .DEN_BITS(16)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_dur),
        .o_ctl   (w_div),
        .o_quot  (w_quot)
    );

    // one start per division
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_started <= 1'b0;
        else if (r_state != ST_DIV) r_started <= 1'b0;
        else r_started <= 1'b1;
    end

    // the last flag: search ahead for a later reporting slot is not possible,
    // so results are held one back and last is set on the held one at the end
    assign w_push  = (r_state == ST_EMIT) && r_emit && w_out_free;
    assign w_flush = (r_state == ST_NEXT) && (r_idx == CWD'(SLOTS - 1)) && r_hold_v;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            if (w_push) begin
                r_hold_v <= 1'b1;
                if (r_hold_v) begin
                    r_ovalid <= 1'b1;
                    r_odata  <= r_hold;
                end else if (!i_out_stall) begin
                    r_ovalid <= 1'b0;
                end
                r_hold <= '{out_slot: 4'(w_idx), value: 16'(r_val),
                            finished: r_fin, last: 1'b0};
            end else if (w_flush && w_out_free) begin
                r_hold_v <= 1'b0;
                r_ovalid <= 1'b1;
                r_odata  <= '{out_slot: r_hold.out_slot, value: r_hold.value,
                              finished: r_hold.finished, last: 1'b1};
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

`ifndef NO_ASSERTIONS
    // the walk index stays inside the table
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_idx < CWD'(SLOTS))) else $error("walk index out of range");
    // the divider only runs during a division phase
    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> (r_state == ST_DIV)) else $error("divider busy outside division");
    // a held result always exists before an output is loaded from it
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_ovalid)) |-> $past(r_hold_v)) else $error("output without held result");
`endif
endmodule

>>> src/mslte_div.sv
// Restoring serial divider, one quotient bit per cycle, truncating toward zero.
// Depends on mslte_pkg for the control struct.
`timescale 1ns / 1ps
module mslte_div import mslte_pkg::*; #(
    parameter int NUM_BITS = 48,
    parameter int DEN_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0]        i_den,
    output t_div_ctl                   o_ctl,
    output logic signed [NUM_BITS-1:0] o_quot
);
    localparam int CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_q, n_q;
    logic [DEN_BITS:0]   r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den;
    logic                r_neg;
    logic [CW-1:0]       r_cnt;
    logic                r_busy, r_done;
    logic [DEN_BITS:0]   w_trial;
    logic [DEN_BITS:0]   w_shift;

    // one restoring step
    always_comb begin
        w_shift = {r_rem[DEN_BITS-1:0], r_q[NUM_BITS-1]};
        w_trial = w_shift - {1'b0, r_den};
        n_q     = {r_q[NUM_BITS-2:0], ~w_trial[DEN_BITS]};
        n_rem   = w_trial[DEN_BITS] ? w_shift : w_trial;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_BITS-1];
            r_q   <= i_num[NUM_BITS-1] ? NUM_BITS'(-i_num) : i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_quot      = r_neg ? -$signed(r_q) : $signed(r_q);
    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
endmodule
